### design/fbpa_pkg.sv
`timescale 1ns / 1ps
// Types, codes and constants shared by the block pool allocator modules
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int TOTAL_RST_CAP  = 1024;

    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SIZE_W    = 13;
    localparam int OFS_W     = 22;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] BSIZE_MIN = 13'd8;
    localparam logic [SIZE_W-1:0] BSIZE_MAX = 13'd4096;
    localparam logic [SIZE_W-1:0] BSIZE_RST = 13'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_RESET = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_action          action;
        logic [IDX_W-1:0] block_index;
    } t_cmd_in;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted_index;
        logic [OFS_W-1:0] byte_offset;
        logic [CNT_W-1:0] free_count;
    } t_result;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_REPORT,
        DP_PUSH,
        DP_MARK,
        DP_LINK_RD,
        DP_LINK_POP,
        DP_RESTART
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_ctl;

    typedef struct packed {
        logic free_zero;
        logic head_valid;
        logic mark_avail;
        logic idx_oor;
        logic pool_full;
    } t_dp_flags;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

endpackage

### design/fbpa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/fbpa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: decodes each command into datapath operations
module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fbpa_pkg::t_action   i_action,
    input  fbpa_pkg::t_dp_flags i_flags,
    output logic                o_busy,
    output fbpa_pkg::t_dp_ctl   o_ctl
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl.op   = DP_IDLE;
        o_ctl.code = STAT_OK;
        o_busy     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_ALLOC: begin
                            if (i_flags.free_zero) begin
                                o_ctl.op   = DP_REPORT;
                                o_ctl.code = STAT_EMPTY;
                            end else if (i_flags.head_valid) begin
                                // successor of the head comes back from the link RAM
                                o_ctl.op = DP_LINK_RD;
                                n_state  = ST_POP;
                            end else if (i_flags.mark_avail) begin
                                o_ctl.op = DP_MARK;
                            end else begin
                                // only reachable after a double free
                                o_ctl.op   = DP_REPORT;
                                o_ctl.code = STAT_EMPTY;
                            end
                        end
                        ACT_FREE: begin
                            if (i_flags.idx_oor) begin
                                o_ctl.op   = DP_REPORT;
                                o_ctl.code = STAT_RANGE;
                            end else if (i_flags.pool_full) begin
                                o_ctl.op   = DP_REPORT;
                                o_ctl.code = STAT_FULL;
                            end else begin
                                o_ctl.op = DP_PUSH;
                            end
                        end
                        ACT_RESET: begin
                            o_ctl.op = DP_RESTART;
                        end
                        ACT_NOP: begin
                            o_ctl.op = DP_REPORT;
                        end
                        default: begin
                            o_ctl.op = DP_IDLE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_busy   = 1'b1;
                o_ctl.op = DP_LINK_POP;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### design/fbpa_dp.sv
`timescale 1ns / 1ps
// Datapath: pool registers, link RAM, offset multiplier and result register
module fbpa_dp #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fbpa_pkg::t_dp_ctl                  i_ctl,
    input  fbpa_pkg::t_cmd_in                  i_cmd,
    input  logic                               i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fbpa_pkg::SIZE_W-1:0]        i_cfg_data,
    output fbpa_pkg::t_dp_flags                o_flags,
    output logic                               o_strobe,
    output fbpa_pkg::t_result                  o_result
);
    import fbpa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = AW + SIZE_W;
    localparam logic [LW-1:0] NO_BLOCK  = LW'(MAX_BLOCKS);
    localparam logic [LW-1:0] TOTAL_RST =
        LW'((MAX_BLOCKS < TOTAL_RST_CAP) ? MAX_BLOCKS : TOTAL_RST_CAP);

    logic [LW-1:0]     r_total, n_total;
    logic [SIZE_W-1:0] r_bsize, n_bsize;
    logic [LW-1:0]     r_head,  n_head;
    logic [LW-1:0]     r_mark,  n_mark;
    logic [LW-1:0]     r_free,  n_free;
    logic              r_valid, n_valid;
    t_result           r_res,   n_res;

    logic [CNT_W-1:0]  cfg_total_raw;
    logic [LW-1:0]     cfg_total;
    logic [SIZE_W-1:0] cfg_bsize;
    logic [LW-1:0]     link_rdata;
    logic [LW-1:0]     link_next;
    logic [AW-1:0]     grant_idx;
    logic [PW-1:0]     grant_prod;

    fbpa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.op == DP_PUSH),
        .i_waddr (AW'(i_cmd.block_index)),
        .i_wdata (r_head),
        .i_re    (i_ctl.op == DP_LINK_RD),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (link_rdata)
    );

    // register write clamping
    always_comb begin
        cfg_total_raw = i_cfg_data[CNT_W-1:0];
        if (cfg_total_raw == '0) begin
            cfg_total = LW'(1);
        end else if (32'(cfg_total_raw) > 32'(MAX_BLOCKS)) begin
            cfg_total = NO_BLOCK;
        end else begin
            cfg_total = LW'(cfg_total_raw);
        end
        if (i_cfg_data < BSIZE_MIN) begin
            cfg_bsize = BSIZE_MIN;
        end else if (i_cfg_data > BSIZE_MAX) begin
            cfg_bsize = BSIZE_MAX;
        end else begin
            cfg_bsize = i_cfg_data;
        end
    end

    always_comb begin
        o_flags.free_zero  = (r_free == '0);
        o_flags.head_valid = (r_head < NO_BLOCK);
        o_flags.mark_avail = (r_mark < r_total);
        o_flags.idx_oor    = (32'(i_cmd.block_index) >= 32'(r_total));
        o_flags.pool_full  = (r_free >= r_total);
    end

    assign link_next  = (link_rdata > NO_BLOCK) ? NO_BLOCK : link_rdata;
    assign grant_idx  = (i_ctl.op == DP_LINK_POP) ? r_head[AW-1:0] : r_mark[AW-1:0];
    assign grant_prod = PW'(grant_idx) * PW'(r_bsize);

    always_comb begin
        n_total = r_total;
        n_bsize = r_bsize;
        n_head  = r_head;
        n_mark  = r_mark;
        n_free  = r_free;
        n_valid = 1'b0;

        n_res.status        = STAT_OK;
        n_res.granted_index = '0;
        n_res.byte_offset   = '0;

        case (i_ctl.op) inside
            DP_REPORT: begin
                n_valid      = 1'b1;
                n_res.status = i_ctl.code;
            end
            DP_PUSH: begin
                n_valid = 1'b1;
                n_head  = LW'(i_cmd.block_index);
                n_free  = r_free + LW'(1);
            end
            DP_MARK, DP_LINK_POP: begin
                n_valid             = 1'b1;
                n_free              = r_free - LW'(1);
                n_res.granted_index = IDX_W'(grant_idx);
                n_res.byte_offset   = OFS_W'(grant_prod);
                if (i_ctl.op == DP_MARK) begin
                    n_mark = r_mark + LW'(1);
                end else begin
                    n_head = link_next;
                end
            end
            DP_RESTART: begin
                n_valid = 1'b1;
                n_head  = NO_BLOCK;
                n_mark  = '0;
                n_free  = r_total;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase

        n_res.free_count = CNT_W'(n_free);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOTAL_BLOCKS: begin
                    // a new block count also restarts the pool
                    n_total = cfg_total;
                    n_head  = NO_BLOCK;
                    n_mark  = '0;
                    n_free  = cfg_total;
                end
                CFG_BLOCK_SIZE: begin
                    n_bsize = cfg_bsize;
                end
                default: begin
                    n_bsize = r_bsize;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            r_bsize <= BSIZE_RST;
            r_head  <= NO_BLOCK;
            r_mark  <= '0;
            r_free  <= TOTAL_RST;
            r_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            r_bsize <= n_bsize;
            r_head  <= n_head;
            r_mark  <= n_mark;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_valid;
    assign o_result = r_res;

endmodule

### design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// Fixed-size block pool allocator: LIFO free list of block indices
//
// Command channel: start with i_cmd (action, block_index) is taken at a clock
// edge where busy is low. Actions: allocate, free, reset pool, no operation.
// Result channel: o_strobe is high for exactly one cycle with o_result
// (status, granted_index, byte_offset, free_count); there is no back-pressure.
// The result appears the cycle after the transfer. An allocate served
// from the free list waits on the registered read of the link RAM, so it
// holds busy for one cycle and its result is registered at the end of that
// busy cycle. All other commands may follow back to back.
// Throughput: one command per cycle while busy is low (a pop holds busy).
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write the block count (index 0,
// also restarts the pool) or the block size (index 1) while the block is idle.
// Reset: block count min(MAX_BLOCKS, 1024), block size 64, all blocks free in
// ascending order. The link RAM is not cleared; the high-water mark makes that
// unnecessary, so the block is usable the cycle after reset.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fbpa_pkg::t_cmd_in              i_cmd,
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbpa_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                           o_strobe,
    output fbpa_pkg::t_result              o_result
);
    import fbpa_pkg::*;

    t_dp_ctl   ctl;
    t_dp_flags flags;

    fbpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_cmd.action),
        .i_flags  (flags),
        .o_busy   (busy),
        .o_ctl    (ctl)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_flags    (flags),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

### design/fbpa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the block pool allocator, bound to the top level
module fbpa_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input fbpa_pkg::t_result o_result
);
    import fbpa_pkg::*;

    // busy only follows a transfer, and lasts one cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $past(start && !busy))
        else $error("busy without a preceding transfer");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_strobe))
        else $error("pop did not complete after one wait cycle");

    a_xfer_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("transfer not answered");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start && !busy)))
        else $error("result without a transfer");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != STAT_OK) |->
            (o_result.granted_index == '0 && o_result.byte_offset == '0))
        else $error("failed command reports a granted block");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

### sim/fixed_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed block pool allocator: directed table, then random phases
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int NO_BLOCK    = MAX_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 30;
    localparam int PHASE_ITEMS = 200;
    localparam int CFG_EVERY   = 70;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]    reg_val;
        t_cmd_in              cmd;
        bit                   fixed;
        t_result              res;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd_in              i_cmd;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 o_strobe;
    t_result              o_result;

    // shadow of the pool
    logic [CNT_W-1:0] link_ram [MAX_BLOCKS_DEF];
    int               pool_total = (MAX_BLOCKS_DEF < TOTAL_RST_CAP) ? MAX_BLOCKS_DEF
                                                                    : TOTAL_RST_CAP;
    int               pool_bytes = int'(BSIZE_RST);
    int               list_head  = NO_BLOCK;
    int               next_fresh = 0;
    int               blocks_free = pool_total;

    t_result          owed_results [$];
    logic [IDX_W-1:0] held_blocks [$];
    int               fail_count  = 0;
    int               cycle_count = 0;

    fixed_block_pool_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void pool_restart();
        list_head   = NO_BLOCK;
        next_fresh  = 0;
        blocks_free = pool_total;
    endfunction

    function automatic void pool_outcome(input t_cmd_in c, output t_result r);
        int grant;
        grant = -1;
        r = '0;
        r.status = STAT_OK;
        case (c.action)
            ACT_ALLOC: begin
                if (blocks_free == 0) begin
                    r.status = STAT_EMPTY;
                end else if (list_head < NO_BLOCK) begin
                    grant = list_head;
                    list_head = (int'(link_ram[grant]) > NO_BLOCK) ? NO_BLOCK
                                                                    : int'(link_ram[grant]);
                end else if (next_fresh < pool_total) begin
                    // above the high-water mark blocks are free in ascending order
                    grant = next_fresh;
                    next_fresh++;
                end else begin
                    r.status = STAT_EMPTY;
                end
                if (grant >= 0) begin
                    blocks_free--;
                    r.granted_index = grant[IDX_W-1:0];
                    r.byte_offset   = OFS_W'(grant * pool_bytes);
                end
            end
            ACT_FREE: begin
                if (int'(c.block_index) >= pool_total) begin
                    r.status = STAT_RANGE;
                end else if (blocks_free >= pool_total) begin
                    r.status = STAT_FULL;
                end else begin
                    link_ram[c.block_index] = CNT_W'(list_head);
                    list_head = int'(c.block_index);
                    blocks_free++;
                end
            end
            ACT_RESET: pool_restart();
            default: ;
        endcase
        r.free_count = CNT_W'(blocks_free);
    endfunction

    function automatic t_dir_row cmd_row(input t_action act, input int idx);
        t_dir_row row;
        row.is_cfg          = 1'b0;
        row.reg_idx         = '0;
        row.reg_val         = '0;
        row.cmd.action      = act;
        row.cmd.block_index = IDX_W'(idx);
        row.fixed           = 1'b0;
        row.res             = '0;
        return row;
    endfunction

    function automatic t_dir_row chk_row(input t_action act, input int idx, input t_status st,
                                         input int gi, input int ofs, input int fc);
        t_dir_row row;
        row                   = cmd_row(act, idx);
        row.fixed             = 1'b1;
        row.res.status        = st;
        row.res.granted_index = IDX_W'(gi);
        row.res.byte_offset   = OFS_W'(ofs);
        row.res.free_count    = CNT_W'(fc);
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_dir_row row;
        row         = cmd_row(ACT_NOP, 0);
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = SIZE_W'(val);
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (owed_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, o_result);
            end else begin
                want = owed_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("granted_index", 32'(want.granted_index),
                            32'(o_result.granted_index));
                check_field("byte_offset", 32'(want.byte_offset), 32'(o_result.byte_offset));
                check_field("free_count", 32'(want.free_count), 32'(o_result.free_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one command transfer; start is left high for the caller to keep or drop
    task automatic issue_cmd(input t_cmd_in c, input bit fixed, input t_result fixed_res,
                             output t_result predicted);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pool_outcome(c, predicted);
        owed_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // each further cycle stays idle with the same odds, so pct is roughly the idle share
    task automatic sender_pause(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        int v;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TOTAL_BLOCKS) begin
            v = int'(val[CNT_W-1:0]);
            if (v == 0) v = 1;
            if (v > NO_BLOCK) v = NO_BLOCK;
            pool_total = v;
            pool_restart();
        end else begin
            v = int'(val);
            if (v < int'(BSIZE_MIN)) v = int'(BSIZE_MIN);
            if (v > int'(BSIZE_MAX)) v = int'(BSIZE_MAX);
            pool_bytes = v;
        end
        @(posedge i_clk);
    endtask

    // mostly frees of blocks actually held, so small pools cycle through empty and full
    task automatic random_run(input int n_items, input int gap_pct);
        t_cmd_in c;
        t_result r;
        int      sel;
        int      j;
        int      tot_val;
        int      sz_val;
        bit      from_held;
        for (int k = 0; k < n_items; k++) begin
            if (k % CFG_EVERY == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: tot_val = $urandom_range(1, 12);
                    6:                tot_val = 0;
                    7:                tot_val = NO_BLOCK;
                    8:                tot_val = $urandom_range(0, 8191);
                    default:          tot_val = $urandom_range(13, 100);
                endcase
                sz_val = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(8, 128);
                drain();
                write_reg(CFG_TOTAL_BLOCKS, SIZE_W'(tot_val));
                write_reg(CFG_BLOCK_SIZE, SIZE_W'(sz_val));
                held_blocks.delete();
            end
            c.block_index = IDX_W'($urandom);
            from_held = 1'b0;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                c.action = ACT_ALLOC;
            end else if (sel < 80 && held_blocks.size() > 0) begin
                j = $urandom_range(0, held_blocks.size() - 1);
                c.action = ACT_FREE;
                c.block_index = held_blocks[j];
                from_held = 1'b1;
            end else if (sel < 90) begin
                c.action = ACT_FREE;
            end else if (sel < 94) begin
                c.action = ACT_RESET;
            end else if (sel < 97) begin
                c.action = ACT_NOP;
            end else begin
                c.action = ACT_ALLOC;
            end
            issue_cmd(c, 1'b0, '0, r);
            if (from_held) held_blocks.delete(j);
            if (c.action == ACT_ALLOC && r.status == STAT_OK)
                held_blocks.push_back(r.granted_index);
            if (c.action == ACT_RESET) held_blocks.delete();
            sender_pause(gap_pct);
        end
    endtask

    initial begin
        t_dir_row rows [DIR_ROWS];
        t_result  r;
        rows[0]  = chk_row(ACT_NOP, 'h3FF, STAT_OK, 0, 0, 1024);
        rows[1]  = chk_row(ACT_ALLOC, 0, STAT_OK, 0, 0, 1023);
        rows[2]  = chk_row(ACT_ALLOC, 'h3FF, STAT_OK, 1, 64, 1022);
        rows[3]  = chk_row(ACT_FREE, 1023, STAT_OK, 0, 0, 1023);
        rows[4]  = cmd_row(ACT_ALLOC, 0);
        rows[5]  = cmd_row(ACT_FREE, 0);
        rows[6]  = chk_row(ACT_RESET, 'h2AA, STAT_OK, 0, 0, 1024);
        rows[7]  = chk_row(ACT_FREE, 5, STAT_FULL, 0, 0, 1024);
        rows[8]  = cfg_row(CFG_TOTAL_BLOCKS, 2);
        rows[9]  = cfg_row(CFG_BLOCK_SIZE, 4096);
        rows[10] = chk_row(ACT_ALLOC, 0, STAT_OK, 0, 0, 1);
        rows[11] = chk_row(ACT_ALLOC, 0, STAT_OK, 1, 4096, 0);
        rows[12] = chk_row(ACT_ALLOC, 'h155, STAT_EMPTY, 0, 0, 0);
        rows[13] = chk_row(ACT_FREE, 2, STAT_RANGE, 0, 0, 0);
        rows[14] = chk_row(ACT_FREE, 1023, STAT_RANGE, 0, 0, 0);
        rows[15] = chk_row(ACT_FREE, 1, STAT_OK, 0, 0, 1);
        // same block again: double free goes through
        rows[16] = chk_row(ACT_FREE, 1, STAT_OK, 0, 0, 2);
        rows[17] = cmd_row(ACT_ALLOC, 0);
        rows[18] = cmd_row(ACT_ALLOC, 0);
        rows[19] = cmd_row(ACT_ALLOC, 0);
        rows[20] = cfg_row(CFG_TOTAL_BLOCKS, 0);
        rows[21] = cfg_row(CFG_BLOCK_SIZE, 0);
        rows[22] = chk_row(ACT_ALLOC, 0, STAT_OK, 0, 0, 0);
        rows[23] = chk_row(ACT_ALLOC, 0, STAT_EMPTY, 0, 0, 0);
        rows[24] = cfg_row(CFG_TOTAL_BLOCKS, 'h1FFF);
        rows[25] = cfg_row(CFG_BLOCK_SIZE, 'h1FFF);
        rows[26] = cmd_row(ACT_ALLOC, 0);
        rows[27] = cmd_row(ACT_FREE, 1023);
        // top block at the largest size: widest byte offset
        rows[28] = cmd_row(ACT_ALLOC, 0);
        rows[29] = cmd_row(ACT_NOP, 0);

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            if (rows[n].is_cfg) begin
                drain();
                write_reg(rows[n].reg_idx, rows[n].reg_val);
            end else begin
                issue_cmd(rows[n].cmd, rows[n].fixed, rows[n].res, r);
                sender_pause(18);
            end
        end

        random_run(PHASE_ITEMS, 18);
        random_run(PHASE_ITEMS, 82);
        random_run(PHASE_ITEMS, 0);

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
